FILE: rtl/sdlr_pkg.sv
package sdlr_pkg;

   // Sample width is fixed by the payload format.
   localparam int SAMPLE_BITS = 16;
   // Default fraction width of the position accumulator.
   localparam int FRAC_BITS_DEFAULT = 16;
   // Width of the step ratio register and its reset value (ratio 1.0 in Q4.16).
   localparam int STEP_W = 20;
   localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
      logic                          last_frame;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mono_out;
      logic                          last_in_run;
   } rsp_payload_type;

   // Commands from the controller to the datapath; at most one is high in a cycle.
   typedef struct packed {
      logic load;
      logic mul;
      logic emit_interp;
      logic end_interp;
      logic emit_tail;
      logic finish;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic interp_go;
      logic tail_go;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/sdlr_ctrl.sv
module sdlr_ctrl
   import sdlr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_EMIT  = 2'd2;
   localparam logic [1:0] S_TAIL  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.interp_go) begin
               cmd.mul  = 1'b1;
               state_in = S_EMIT;
            end else begin
               cmd.end_interp = 1'b1;
               state_in       = S_TAIL;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_interp = 1'b1;
               state_in        = S_CHECK;
            end
         end
         S_TAIL: begin
            if (status.tail_go) begin
               if (status.out_free) begin
                  cmd.emit_tail = 1'b1;
               end
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CHECK))
      else $error("accepted beat did not start evaluation");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_interp || cmd.emit_tail) |-> status.out_free)
      else $error("result emitted while output register is occupied");

   a_emit_after_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> ($past(state_ff) == S_CHECK || $past(state_ff) == S_EMIT))
      else $error("interpolation emit entered without a product");
`endif

endmodule

FILE: rtl/sdlr_datapath.sv
module sdlr_datapath
   import sdlr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      cmd,
   output dp_status_type   status,
   input  req_payload_type req_payload,
   input  logic            csr_write,
   input  logic [STEP_W-1:0] csr_data,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   localparam int SB = SAMPLE_BITS;
   localparam int PW = FRAC_BITS + 4;
   localparam int CW = (PW > STEP_W) ? PW : STEP_W;
   localparam int PRW = SB + FRAC_BITS + 2;
   localparam logic [PW-1:0] ONE_POS  = PW'(1) << FRAC_BITS;
   localparam logic [PW-1:0] TWO_POS  = PW'(2) << FRAC_BITS;
   localparam logic [CW-1:0] STEP_MIN = CW'(1) << (FRAC_BITS - 1);
   localparam logic [CW-1:0] STEP_MAX = CW'(12) << FRAC_BITS;

   logic [STEP_W-1:0]     step_ff, step_in;
   logic [PW-1:0]         phase_ff, phase_in;
   logic signed [SB-1:0]  held_ff, held_in;
   logic                  have_held_ff, have_held_in;
   logic signed [SB-1:0]  cur_mono_ff, cur_mono_in;
   logic                  cur_last_ff, cur_last_in;
   logic signed [PRW-1:0] prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [CW-1:0]         step_wide;
   logic [CW-1:0]         step_clamped;
   logic [PW-1:0]         step_used;
   logic signed [SB:0]    mono_sum;
   logic signed [SB:0]    diff;
   logic signed [FRAC_BITS:0] frac;
   logic signed [PRW-1:0] prod;
   logic signed [SB-1:0]  interp_val;
   logic [PW-1:0]         phase_next;
   logic                  more_interp;
   logic                  more_tail;

   always_comb begin
      step_wide = CW'(step_ff);
      if (step_wide < STEP_MIN) begin
         step_clamped = STEP_MIN;
      end else if (step_wide > STEP_MAX) begin
         step_clamped = STEP_MAX;
      end else begin
         step_clamped = step_wide;
      end
   end
   assign step_used = step_clamped[PW-1:0];

   // Downmix: arithmetic shift of the sum rounds toward minus infinity.
   assign mono_sum = {req_payload.left_sample[SB-1], req_payload.left_sample}
                   + {req_payload.right_sample[SB-1], req_payload.right_sample};

   // m0 + floor((m1 - m0) * f / ONE) equals the floor of the two-tap weighted sum.
   assign diff       = {cur_mono_ff[SB-1], cur_mono_ff} - {held_ff[SB-1], held_ff};
   assign frac       = {1'b0, phase_ff[FRAC_BITS-1:0]};
   assign prod       = diff * frac;
   assign interp_val = held_ff + prod_ff[FRAC_BITS+SB-1:FRAC_BITS];

   assign phase_next  = phase_ff + step_used;
   assign more_interp = (phase_next < ONE_POS) || (cur_last_ff && (phase_next < TWO_POS));
   assign more_tail   = phase_next < ONE_POS;

   assign status.interp_go = have_held_ff && (phase_ff < ONE_POS);
   assign status.tail_go   = cur_last_ff && (phase_ff < ONE_POS);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      step_in      = step_ff;
      phase_in     = phase_ff;
      held_in      = held_ff;
      have_held_in = have_held_ff;
      cur_mono_in  = cur_mono_ff;
      cur_last_in  = cur_last_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_write) begin
         step_in = csr_data;
      end
      if (cmd.load) begin
         cur_mono_in = mono_sum[SB:1];
         cur_last_in = req_payload.last_frame;
      end
      if (cmd.mul) begin
         prod_in = prod;
      end
      if (cmd.emit_interp) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.mono_out    = interp_val;
         rsp_data_in.last_in_run = !more_interp;
         phase_in                = phase_next;
      end
      if (cmd.end_interp && have_held_ff) begin
         phase_in = phase_ff - ONE_POS;
      end
      if (cmd.emit_tail) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.mono_out    = cur_mono_ff;
         rsp_data_in.last_in_run = !more_tail;
         phase_in                = phase_next;
      end
      if (cmd.finish) begin
         if (cur_last_ff) begin
            phase_in     = '0;
            held_in      = '0;
            have_held_in = 1'b0;
         end else begin
            held_in      = cur_mono_ff;
            have_held_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         phase_ff     <= '0;
         held_ff      <= '0;
         have_held_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         have_held_ff <= have_held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_mono_ff <= cur_mono_in;
      cur_last_ff <= cur_last_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

FILE: rtl/stereo_downmix_linear_resampler_core.sv
// Stereo downmix and linear-interpolation resampler.
// The req channel takes one stereo frame per beat (left, right, last-of-stream
// flag); a beat is taken when req_valid is high and req_stall is low. Each frame
// is averaged to mono and gives zero to two interpolated outputs on the rsp
// channel, plus up to two end-of-stream repeats on the last frame; the final
// output of each frame is flagged by last_in_run. The csr channel writes the
// Q4.16 step ratio (source rate over target rate) when csr_valid and csr_ready
// are both high; write it only between streams or while no frame is in flight.
// Values outside 0.5 to 12.0 are saturated. Frames are processed one at a
// time. Each frame is loaded; each interpolated output then passes through
// the single multiplier and then loads the output register, while each
// end-of-stream repeat loads the output register directly; a final step
// retires the frame.
// The output register holds a result while rsp_stall is high; the sequencer
// waits on it, and req_stall stays high until the frame is finished.
// Reset is synchronous: it empties the output register, restores the ratio to
// 1.0 and clears the held frame and phase, so the next frame starts a stream.
module stereo_downmix_linear_resampler_core
   import sdlr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_payload_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_payload_type   rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [STEP_W-1:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;

   // The ratio register accepts a write in any cycle outside reset.
   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;

   // The sequencer owns the input handshake and issues at most one command per cycle.
   sdlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the phase, the held frame, the multiplier and the
   // output register.
   sdlr_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
